// ===== design/fbks_pkg.sv =====
// Package: key type, cell control and sequencer states shared by the key set design.
`timescale 1ns / 1ps
package fbks_pkg;

	localparam int unsigned ENTRY_COUNT_W = 7;

	typedef enum logic {
		CMD_ADD    = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [63:0] word3;
		logic [63:0] word2;
		logic [63:0] word1;
		logic [63:0] word0;
		logic [31:0] oidx;
	} key_t;

	typedef struct packed {
		logic shift; // take the neighbour's entry
		logic load;  // take the new key
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} state_t;

endpackage

// ===== design/fbks_if.sv =====
// Interfaces: request and response channels of the key set.
`timescale 1ns / 1ps
interface fbks_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [63:0] txid_word3;
	logic [63:0] txid_word2;
	logic [63:0] txid_word1;
	logic [63:0] txid_word0;
	logic [31:0] output_index;

	modport source (output valid, command, txid_word3, txid_word2, txid_word1, txid_word0,
		output_index, input ready);
	modport sink (input valid, command, txid_word3, txid_word2, txid_word1, txid_word0,
		output_index, output ready);
endinterface

interface fbks_rsp_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [6:0] entry_count;

	modport source (output valid, found, entry_count, input ready);
	modport sink (input valid, found, entry_count, output ready);
endinterface

// ===== design/fbks_cell.sv =====
// One storage cell of the key chain: entry, valid flag and registered compare.
`timescale 1ns / 1ps
module fbks_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  fbks_pkg::key_t     cmp_key,
	input  logic               cmp_en,
	input  fbks_pkg::cell_ctl_t ctl,
	input  fbks_pkg::key_t     new_key,
	input  fbks_pkg::key_t     right_key,
	input  logic               right_valid,
	output fbks_pkg::key_t     key,
	output logic               valid,
	output logic               match
);
	import fbks_pkg::*;

	key_t key_q;
	logic valid_q;
	logic match_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= new_key;
		end else if (ctl.shift) begin
			key_q <= right_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				valid_q <= 1'b1;
			end else if (ctl.shift) begin
				valid_q <= right_valid;
			end
			if (cmp_en) begin
				match_q <= valid_q && (key_q == cmp_key);
			end
		end
	end

	assign key   = key_q;
	assign valid = valid_q;
	assign match = match_q;

endmodule

// ===== design/fifo_bounded_key_set.sv =====
// Top level: ordered key set built as a chain of storage cells.
`timescale 1ns / 1ps
// A request is taken in the idle state, where every cell registers its compare against
// it, and its response is registered in the apply state, together with the chain update.
// No new request is taken until that update is done. A held response holds the update
// cycle, and with it the next request. Requests are paced by the compare cycle followed
// by the chain update cycle.
// Reset clears all valid flags, the entry count and the handshake state; stored keys
// are left as they are and are never read while their cell is empty.
module fifo_bounded_key_set #(
	parameter int unsigned DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	fbks_req_if.sink    req,
	fbks_rsp_if.source  rsp
);
	import fbks_pkg::*;

	localparam int unsigned CW     = $clog2(DEPTH + 1);
	localparam int unsigned LEVELS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// sequencer
	state_t state_q, state_d;
	logic   req_ready;
	logic   apply;
	logic   slot_free;
	logic   accept;

	// captured request
	key_t   key_s1;
	logic   cmd_s1;
	key_t   req_key;

	// chain
	key_t      cell_key   [DEPTH];
	logic      cell_valid [DEPTH];
	logic [DEPTH-1:0] match_vec;
	logic [DEPTH-1:0] valid_vec;
	cell_ctl_t cell_ctl   [DEPTH];

	// prefix OR of the match vector: at and above the hit, cells shift down
	logic [DEPTH-1:0] prefix [LEVELS+1];

	logic          hit;
	logic          full;
	logic          is_lookup;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW+ENTRY_COUNT_W-1:0] count_ext;
	logic          rsp_valid_q;
	logic          found_q;
	logic [ENTRY_COUNT_W-1:0] entry_count_q;

	assign req_key = '{word3: req.txid_word3, word2: req.txid_word2,
		word1: req.txid_word1, word0: req.txid_word0, oidx: req.output_index};

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (req.valid) state_d = ST_APPLY;
			ST_APPLY: if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		apply     = 1'b0;
		case (state_q)
			ST_IDLE:  req_ready = 1'b1;
			ST_APPLY: apply = slot_free;
			default: begin
				req_ready = 1'b0;
				apply     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= req_key;
			cmd_s1 <= req.command;
		end
	end

	// Cells compare against the live request in the accept cycle; the chain does not
	// move in that cycle, so the registered matches are exact for the update.
	genvar gi, gl;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			if (gi == DEPTH - 1) begin : g_last
				fbks_cell u_cell (
					.clk         (clk),
					.arst_n      (arst_n),
					.cmp_key     (req_key),
					.cmp_en      (accept),
					.ctl         (cell_ctl[gi]),
					.new_key     (key_s1),
					.right_key   (key_s1),
					.right_valid (1'b0),
					.key         (cell_key[gi]),
					.valid       (cell_valid[gi]),
					.match       (match_vec[gi])
				);
			end else begin : g_mid
				fbks_cell u_cell (
					.clk         (clk),
					.arst_n      (arst_n),
					.cmp_key     (req_key),
					.cmp_en      (accept),
					.ctl         (cell_ctl[gi]),
					.new_key     (key_s1),
					.right_key   (cell_key[gi+1]),
					.right_valid (cell_valid[gi+1]),
					.key         (cell_key[gi]),
					.valid       (cell_valid[gi]),
					.match       (match_vec[gi])
				);
			end
			assign valid_vec[gi] = cell_valid[gi];
		end

		assign prefix[0] = match_vec;
		for (gl = 0; gl < LEVELS; gl++) begin : g_lvl
			assign prefix[gl+1] = prefix[gl] | (prefix[gl] << (1 << gl));
		end
	endgenerate

	assign hit       = |match_vec;
	assign full      = valid_vec[DEPTH-1];
	assign is_lookup = (cmd_s1 == CMD_LOOKUP);

	// Per-cell update. Keys are unique, so at most one cell matches.
	//  lookup hit      : cells at and above the hit take their neighbour's entry
	//  add miss, room  : first empty cell takes the key
	//  add miss, full  : whole chain moves down, the top cell takes the key
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i] = '{shift: 1'b0, load: 1'b0};
			if (apply) begin
				if (is_lookup) begin
					cell_ctl[i].shift = hit && prefix[LEVELS][i];
				end else if (!hit) begin
					if (full) begin
						cell_ctl[i].shift = 1'b1;
						cell_ctl[i].load  = (i == DEPTH - 1);
					end else if (i == 0) begin
						cell_ctl[i].load = !valid_vec[0];
					end else begin
						cell_ctl[i].load = valid_vec[i-1] && !valid_vec[i];
					end
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (is_lookup) begin
			if (hit) count_d = count_q - CW'(1);
		end else if (!hit && !full) begin
			count_d = count_q + CW'(1);
		end
	end

	assign count_ext = {{ENTRY_COUNT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (apply) begin
				count_q <= count_d;
			end
			if (apply) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			found_q       <= hit;
			entry_count_q <= count_ext[ENTRY_COUNT_W-1:0];
		end
	end

	assign req.ready       = req_ready;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = found_q;
	assign rsp.entry_count = entry_count_q;

endmodule
